// ===== rtl/sfr_pkg.sv =====
// sfr_pkg: shared types and byte constants of the stuffed frame transmit framer
// used by sfr_front, sfr_queue, sfr_back and the top level
package sfr_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE  = 8'h7d;
  localparam logic [7:0] FLAG_ESC  = 8'h5e;
  localparam logic [7:0] ESC_ESC   = 8'h5d;
  localparam logic [7:0] CTRL_SEQ0 = 8'h00;
  localparam logic [7:0] CTRL_SEQ1 = 8'h40;

  // one classified payload beat, as handed from front to back
  typedef struct packed {
    logic       hdr;    // first byte of a frame: header goes out first
    logic [7:0] addr;
    logic [7:0] ctrl;
    logic [7:0] data;
    logic       last;   // trailer (check byte and closing flag) follows
    logic [7:0] bcc2;
  } sfr_entry_t;

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

  function automatic logic [7:0] esc_code(input logic [7:0] b);
    return (b == FLAG_BYTE) ? FLAG_ESC : ESC_ESC;
  endfunction

endpackage

// ===== rtl/sfr_front.sv =====
// sfr_front: accepts payload beats, tracks frame state and the running xor,
// builds one sfr_pkg::sfr_entry_t per beat; holds the address register
module sfr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // data_byte
  input  logic              s_tuser,   // sequence_bit
  input  logic              s_tlast,   // last_byte
  input  logic              q_full,
  output logic              q_push,
  output sfr_pkg::sfr_entry_t q_entry
);

  logic       in_frame;
  logic [7:0] running_check;
  logic [7:0] address;
  logic [7:0] check_base;
  logic [7:0] check_new;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign q_push    = s_tvalid && !q_full;

  assign check_base = in_frame ? running_check : 8'h00;
  assign check_new  = check_base ^ s_tdata;

  always_comb begin
    q_entry.hdr  = !in_frame;
    q_entry.addr = address;
    q_entry.ctrl = s_tuser ? sfr_pkg::CTRL_SEQ1 : sfr_pkg::CTRL_SEQ0;
    q_entry.data = s_tdata;
    q_entry.last = s_tlast;
    q_entry.bcc2 = check_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      running_check <= 8'h00;
      address       <= 8'h03;
    end else begin
      if (cfg_valid) begin
        address <= cfg_data;
      end
      if (q_push) begin
        in_frame      <= !s_tlast;
        running_check <= s_tlast ? 8'h00 : check_new;
      end
    end
  end

endmodule

// ===== rtl/sfr_queue.sv =====
// sfr_queue: short first-in first-out queue of classified beats between
// front and back; depends on sfr_pkg for the entry type
module sfr_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sfr_pkg::sfr_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output sfr_pkg::sfr_entry_t head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfr_pkg::sfr_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sfr_back.sv =====
// sfr_back: steps through the bytes of the head entry (header, stuffed data,
// stuffed check byte, closing flag) into the output register; uses sfr_pkg
module sfr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  sfr_pkg::sfr_entry_t head_entry,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // out_byte
  output logic                m_tuser,   // frame_end
  output logic                m_tlast    // run_end
);

  localparam logic [3:0] ST_FLAG     = 4'd0;
  localparam logic [3:0] ST_ADDR     = 4'd1;
  localparam logic [3:0] ST_CTRL     = 4'd2;
  localparam logic [3:0] ST_BCC1     = 4'd3;
  localparam logic [3:0] ST_DATA     = 4'd4;
  localparam logic [3:0] ST_DATA_ESC = 4'd5;
  localparam logic [3:0] ST_BCC2     = 4'd6;
  localparam logic [3:0] ST_BCC2_ESC = 4'd7;
  localparam logic [3:0] ST_CLOSE    = 4'd8;

  logic       busy;
  logic [3:0] step;
  logic [3:0] cur;
  logic [3:0] step_next;
  logic       done;
  logic [7:0] byte_out;
  logic       emit;

  // a fresh entry starts at the header or straight at its data byte
  assign cur  = busy ? step : (head_entry.hdr ? ST_FLAG : ST_DATA);
  assign emit = head_valid && (!m_tvalid || m_tready);
  assign pop  = emit && done;

  always_comb begin
    step_next = cur;
    done      = 1'b0;
    byte_out  = sfr_pkg::FLAG_BYTE;
    unique case (cur)
      ST_FLAG: begin
        byte_out  = sfr_pkg::FLAG_BYTE;
        step_next = ST_ADDR;
      end
      ST_ADDR: begin
        byte_out  = head_entry.addr;
        step_next = ST_CTRL;
      end
      ST_CTRL: begin
        byte_out  = head_entry.ctrl;
        step_next = ST_BCC1;
      end
      ST_BCC1: begin
        byte_out  = head_entry.addr ^ head_entry.ctrl;
        step_next = ST_DATA;
      end
      ST_DATA: begin
        if (sfr_pkg::needs_esc(head_entry.data)) begin
          byte_out  = sfr_pkg::ESC_BYTE;
          step_next = ST_DATA_ESC;
        end else begin
          byte_out  = head_entry.data;
          step_next = ST_BCC2;
          done      = !head_entry.last;
        end
      end
      ST_DATA_ESC: begin
        byte_out  = sfr_pkg::esc_code(head_entry.data);
        step_next = ST_BCC2;
        done      = !head_entry.last;
      end
      ST_BCC2: begin
        if (sfr_pkg::needs_esc(head_entry.bcc2)) begin
          byte_out  = sfr_pkg::ESC_BYTE;
          step_next = ST_BCC2_ESC;
        end else begin
          byte_out  = head_entry.bcc2;
          step_next = ST_CLOSE;
        end
      end
      ST_BCC2_ESC: begin
        byte_out  = sfr_pkg::esc_code(head_entry.bcc2);
        step_next = ST_CLOSE;
      end
      ST_CLOSE: begin
        byte_out = sfr_pkg::FLAG_BYTE;
        done     = 1'b1;
      end
      default: begin
        byte_out = sfr_pkg::FLAG_BYTE;
        done     = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= ST_FLAG;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        busy     <= !done;
        step     <= step_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= byte_out;
      m_tuser <= (cur == ST_CLOSE);
      m_tlast <= done;
    end
  end

endmodule

// ===== rtl/stuffed_frame_transmit_framer.sv =====
// Transmit framer for byte-stuffed frames with xor block check codes. Each
// payload beat on the s_ side is classified at once by the front and queued;
// the back sends one line byte per cycle on the m_ side while m_tready and
// the queue allow. A plain payload byte becomes one line byte, an escaped one
// (0x7e or 0x7d) two; the first byte of a frame adds four header bytes and the
// last adds two or three trailer bytes, up to nine line bytes for a one-byte
// frame. The sustained rate is set by the single-byte output register, with
// the QUEUE_DEPTH-entry queue absorbing header and trailer bursts. The
// address register is written on cfg_ beats and should be changed only while
// the framer is idle. Depends on sfr_pkg, sfr_front, sfr_queue, sfr_back.
module stuffed_frame_transmit_framer #(
  parameter int QUEUE_DEPTH = 4   // 2 or more
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,    // address_byte
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,     // data_byte
  input  logic       s_tuser,     // sequence_bit
  input  logic       s_tlast,     // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,     // out_byte
  output logic       m_tuser,     // frame_end
  output logic       m_tlast      // run_end
);

  logic                q_full;
  logic                q_push;
  sfr_pkg::sfr_entry_t q_entry;
  logic                q_pop;
  logic                head_valid;
  sfr_pkg::sfr_entry_t head_entry;

  sfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  sfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

// ===== tb/stuffed_frame_transmit_framer_test.sv =====
`timescale 1ns / 100ps
// stuffed_frame_transmit_framer_test: self-checking bench for the stuffed frame framer
// drives payload and address beats, predicts the framed line byte stream and checks each beat
// depends on sfr_pkg and stuffed_frame_transmit_framer
module stuffed_frame_transmit_framer_test;

  localparam int LIMIT = 300000;
  localparam int SETTLE_CYCLES = 40;
  localparam int GAP_PCT = 27;

  typedef struct packed {
    logic [7:0] data;
    logic       seq;
    logic       last;
  } payload_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_end;
    logic       frame_end;
  } line_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;    // data_byte
  logic       s_tuser;    // sequence_bit
  logic       s_tlast;    // last_byte
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;    // out_byte
  logic       m_tuser;    // frame_end
  logic       m_tlast;    // run_end

  payload_t   pending[$];
  line_t      line_due[$];
  payload_t   on_wire;
  line_t      due_now;
  logic       frame_open = 1'b0;
  logic [7:0] frame_xor = 8'h00;
  logic [7:0] hdr_addr = 8'h03;
  int         items_queued = 0;
  int         items_taken = 0;
  int         fails = 0;
  int         cycle_count = 0;
  bit         no_gaps = 1'b0;

  stuffed_frame_transmit_framer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic void put_line(input logic [7:0] b, input logic fend);
    line_t beat;
    beat.line_byte = b;
    beat.run_end = 1'b0;
    beat.frame_end = fend;
    line_due.push_back(beat);
  endfunction

  function automatic void put_stuffed(input logic [7:0] b);
    if (b == sfr_pkg::FLAG_BYTE) begin
      put_line(sfr_pkg::ESC_BYTE, 1'b0);
      put_line(sfr_pkg::FLAG_ESC, 1'b0);
    end else if (b == sfr_pkg::ESC_BYTE) begin
      put_line(sfr_pkg::ESC_BYTE, 1'b0);
      put_line(sfr_pkg::ESC_ESC, 1'b0);
    end else begin
      put_line(b, 1'b0);
    end
  endfunction

  // line bytes caused by one payload beat, appended to line_due
  function automatic void encode_payload(input payload_t p);
    logic [7:0] ctrl_byte;
    line_t      tail;
    if (!frame_open) begin
      ctrl_byte = p.seq ? sfr_pkg::CTRL_SEQ1 : sfr_pkg::CTRL_SEQ0;
      // header goes out raw, even when it holds flag or escape values
      put_line(sfr_pkg::FLAG_BYTE, 1'b0);
      put_line(hdr_addr, 1'b0);
      put_line(ctrl_byte, 1'b0);
      put_line(hdr_addr ^ ctrl_byte, 1'b0);
      frame_xor = 8'h00;
      frame_open = 1'b1;
    end
    put_stuffed(p.data);
    frame_xor = frame_xor ^ p.data;
    if (p.last) begin
      put_stuffed(frame_xor);
      put_line(sfr_pkg::FLAG_BYTE, 1'b1);
      frame_open = 1'b0;
      frame_xor = 8'h00;
    end
    tail = line_due.pop_back();
    tail.run_end = 1'b1;
    line_due.push_back(tail);
  endfunction

  function automatic void add_item(input logic [7:0] d, input logic s, input logic l);
    payload_t p;
    p.data = d;
    p.seq = s;
    p.last = l;
    pending.push_back(p);
    items_queued++;
  endfunction

  // whole frames only, mostly short, with flag and escape bytes made common
  function automatic void queue_frames(input int n);
    int left;
    int len;
    logic [7:0] d;
    left = n;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(5, 1);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(9))
          0: d = sfr_pkg::FLAG_BYTE;
          1: d = sfr_pkg::ESC_BYTE;
          default: d = 8'($urandom_range(255));
        endcase
        add_item(d, 1'($urandom_range(1)), i == len - 1);
      end
      left -= len;
    end
  endfunction

  task automatic wait_line_idle();
    while (items_taken != items_queued || line_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_address(input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    hdr_addr = v;
  endtask

  // payload driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        encode_payload(on_wire);
        items_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
          on_wire = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= on_wire.data;
          s_tuser <= on_wire.seq;
          s_tlast <= on_wire.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // line monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (line_due.size() == 0) begin
          $error("unexpected beat: out_byte %h run_end %b frame_end %b",
                 m_tdata, m_tlast, m_tuser);
          fails++;
        end else begin
          due_now = line_due.pop_front();
          if (m_tdata !== due_now.line_byte) begin
            $error("out_byte expected %h actual %h", due_now.line_byte, m_tdata);
            fails++;
          end
          if (m_tlast !== due_now.run_end) begin
            $error("run_end expected %b actual %b", due_now.run_end, m_tlast);
            fails++;
          end
          if (m_tuser !== due_now.frame_end) begin
            $error("frame_end expected %b actual %b", due_now.frame_end, m_tuser);
            fails++;
          end
        end
      end
      m_tready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("stuffed_frame_transmit_framer: mismatch");
      $finish;
    end
  end

  initial begin
    cfg_valid = 1'b0;
    cfg_data = 8'h00;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // address still at its reset value
    add_item(sfr_pkg::FLAG_BYTE, 1'b0, 1'b1);   // one-byte frame, payload and check escaped
    add_item(sfr_pkg::ESC_BYTE, 1'b1, 1'b1);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hff, 1'b0, 1'b0);       // sequence bit ignored mid-frame
    add_item(sfr_pkg::FLAG_BYTE, 1'b0, 1'b0);
    add_item(sfr_pkg::ESC_BYTE, 1'b1, 1'b0);
    add_item(8'h55, 1'b0, 1'b1);
    add_item(8'h10, 1'b0, 1'b0);
    add_item(8'h6d, 1'b1, 1'b1);       // check byte comes out as escape
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'hff, 1'b1, 1'b1);
    wait_line_idle();

    set_address(sfr_pkg::FLAG_BYTE);   // header address and bcc1 equal to the flag
    add_item(8'h41, 1'b0, 1'b1);
    add_item(8'h3c, 1'b1, 1'b0);
    add_item(8'h42, 1'b0, 1'b1);
    wait_line_idle();

    set_address(8'h3d);                // bcc1 equals escape with control 0x40
    add_item(sfr_pkg::FLAG_BYTE, 1'b1, 1'b1);
    add_item(8'h01, 1'b0, 1'b1);
    wait_line_idle();

    set_address(8'h00);
    queue_frames(40);
    wait_line_idle();

    no_gaps = 1'b1;
    set_address(8'hff);
    queue_frames(40);
    wait_line_idle();
    no_gaps = 1'b0;

    set_address(8'($urandom_range(255)));
    queue_frames(37);
    wait_line_idle();

    set_address(sfr_pkg::ESC_BYTE);
    queue_frames(37);
    wait_line_idle();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("stuffed_frame_transmit_framer: match");
    end else begin
      $display("stuffed_frame_transmit_framer: mismatch");
    end
    $finish;
  end

endmodule
